// File: design/sfcs_pkg.sv
package sfcs_pkg;

  typedef enum logic [2:0] {
    KIND_SPI      = 3'd0,
    KIND_HOST     = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_REJECT   = 3'd3,
    KIND_DESELECT = 3'd4
  } kind_e;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_WDATA   = 2'd1;
  localparam logic [1:0] OP_REPLY   = 2'd2;

  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_SECTOR = 3'd2;
  localparam logic [2:0] CMD_PAGE   = 3'd3;
  localparam logic [2:0] CMD_RDID   = 3'd4;

  localparam logic [7:0] OPC_READ   = 8'hD2;
  localparam logic [7:0] OPC_WRITE  = 8'h82;
  localparam logic [7:0] OPC_RDID   = 8'h9F;
  localparam logic [7:0] OPC_STATUS = 8'hD7;
  localparam logic [7:0] OPC_SECTOR = 8'h7C;
  localparam logic [7:0] OPC_PAGE   = 8'h81;
  localparam logic [7:0] FILLER     = 8'hA5;
  localparam int         READY_POS  = 7;
  localparam int         ID_BYTES   = 4;
  localparam int         ADDR_W     = 24;
  localparam int         LEN_W      = 16;

  // Slot order in which a job's results leave the back end.
  localparam int NUM_SLOTS  = 7;
  localparam int SLOT_PRE   = 0;
  localparam int SLOT_H0    = 1;
  localparam int SLOT_H1    = 2;
  localparam int SLOT_H2    = 3;
  localparam int SLOT_H3    = 4;
  localparam int SLOT_POST0 = 5;
  localparam int SLOT_POST1 = 6;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  spi_byte;
    logic        sel;
    logic        rel;
    logic        reply;
    logic [7:0]  host_byte;
    logic [31:0] id_word;
  } item_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] en;
    item_t                pre;
    logic [7:0]           opc;
    logic [ADDR_W-1:0]    addr;
    logic                 rel_last;
    item_t                post0;
    item_t                post1;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  function automatic item_t spi_item(logic [7:0] b, logic sel, logic rel, logic reply);
    item_t it;
    it           = '0;
    it.kind      = KIND_SPI;
    it.spi_byte  = b;
    it.sel       = sel;
    it.rel       = rel;
    it.reply     = reply;
    return it;
  endfunction

  function automatic item_t info_item(kind_e k, logic [7:0] host, logic [31:0] id);
    item_t it;
    it           = '0;
    it.kind      = k;
    it.host_byte = host;
    it.id_word   = id;
    return it;
  endfunction

endpackage

// File: design/sfcs_front.sv
module sfcs_front import sfcs_pkg::*; #(
  parameter int PAGE_BYTES   = 528,
  parameter int READ_DUMMIES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [2:0]        command_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [7:0]        data_byte_i,
  input  logic              q_room_i,
  output job_push_t         push_o
);

  localparam int OW  = $clog2(PAGE_BYTES);
  localparam int PW  = $clog2(PAGE_BYTES + 1);
  localparam int RS  = 36;
  localparam int PRW = RS + ADDR_W;
  localparam logic [PW-1:0]     PAGE_P   = PW'(PAGE_BYTES);
  localparam logic [OW-1:0]     PAGE_MAX = OW'(PAGE_BYTES - 1);
  localparam logic [ADDR_W-1:0] PAGE_A   = ADDR_W'(PAGE_BYTES);
  localparam logic [32:0]       RECIP    =
    33'(((64'd1 << RS) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));
  localparam logic [2:0]        DUMMIES  = 3'(READ_DUMMIES);

  typedef enum logic [2:0] {
    PH_IDLE, PH_DUMMY, PH_RDATA, PH_ID, PH_WDATA, PH_POLL, PH_DIV
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [ADDR_W-1:0] cursor_q, cursor_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic [PW-1:0]     room_q, room_d;
  logic [OW-1:0]     off_q, off_d;
  logic [2:0]        dum_q, dum_d;
  logic [31:0]       gather_q, gather_d;
  logic              cnt_q, cnt_d;
  logic [ADDR_W-1:0] quot_q, quot_d;

  logic              accept;
  logic [PRW-1:0]    prod;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] diff;
  logic [OW-1:0]     off_new;
  logic [PW-1:0]     pr_new;
  logic [LEN_W-1:0]  bl_new;
  logic [2:0]        dl_new;
  logic [31:0]       gather_new;
  job_t              job;

  function automatic item_t rc_item(logic [2:0] dl, logic [LEN_W-1:0] bl);
    if (dl != 3'd0) begin
      return spi_item(FILLER, 1'b0, (dl == 3'd1) && (bl == '0), 1'b1);
    end else if (bl != '0) begin
      return spi_item(FILLER, 1'b0, bl == LEN_W'(1), 1'b1);
    end
    return info_item(KIND_DONE, 8'd0, 32'd0);
  endfunction

  function automatic phase_e rc_phase(logic [2:0] dl, logic [LEN_W-1:0] bl);
    if (dl != 3'd0) begin
      return PH_DUMMY;
    end else if (bl != '0) begin
      return PH_RDATA;
    end
    return PH_IDLE;
  endfunction

  // Bytes of the next write piece: room up to the page end, capped by what is left.
  function automatic logic [PW-1:0] piece_room(logic [OW-1:0] off, logic [LEN_W-1:0] bl);
    logic [PW-1:0] room;
    room = PAGE_P - PW'(off);
    if (LEN_W'(room) > bl) begin
      return PW'(bl);
    end
    return room;
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (phase_q != PH_DIV) && q_room_i;

  // The page quotient comes from a reciprocal multiply that is exact over the
  // whole address range; the offset is the cursor minus quotient times page size.
  assign prod    = PRW'(cursor_q) * PRW'(RECIP);
  assign base    = quot_q * PAGE_A;
  assign diff    = cursor_q - base;
  assign off_new = diff[OW-1:0];

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    cursor_d = cursor_q;
    left_d   = left_q;
    room_d   = room_q;
    off_d    = off_q;
    dum_d    = dum_q;
    gather_d = gather_q;
    cnt_d    = cnt_q;
    quot_d   = quot_q;
    job      = '0;
    pr_new     = (room_q == '0) ? room_q : room_q - PW'(1);
    bl_new     = (left_q == '0) ? left_q : left_q - LEN_W'(1);
    dl_new     = dum_q - 3'd1;
    gather_new = {gather_q[23:0], data_byte_i};

    if (phase_q == PH_DIV) begin
      if (cnt_q) begin
        quot_d = prod[RS +: ADDR_W];
        cnt_d  = 1'b0;
      end else if (q_room_i) begin
        off_d        = off_new;
        room_d       = piece_room(off_new, left_q);
        job.en       = '0;
        job.en[SLOT_H0] = 1'b1;
        job.en[SLOT_H1] = 1'b1;
        job.en[SLOT_H2] = 1'b1;
        job.en[SLOT_H3] = 1'b1;
        job.opc      = OPC_WRITE;
        job.addr     = cursor_q;
        job.rel_last = 1'b0;
        phase_d      = PH_WDATA;
      end
    end else if (accept) begin
      case (op_i)
        OP_REQUEST: begin
          if (phase_q != PH_IDLE || command_i > CMD_RDID) begin
            job.en[SLOT_PRE] = 1'b1;
            job.pre          = info_item(KIND_REJECT, 8'd0, 32'd0);
          end else begin
            cmd_d    = command_i;
            cursor_d = address_i;
            left_d   = length_i;
            case (command_i)
              CMD_READ: begin
                dum_d        = DUMMIES;
                job.en[SLOT_H0]    = 1'b1;
                job.en[SLOT_H1]    = 1'b1;
                job.en[SLOT_H2]    = 1'b1;
                job.en[SLOT_H3]    = 1'b1;
                job.en[SLOT_POST0] = 1'b1;
                job.opc      = OPC_READ;
                job.addr     = address_i;
                job.rel_last = (DUMMIES == 3'd0) && (length_i == '0);
                job.post0    = rc_item(DUMMIES, length_i);
                phase_d      = rc_phase(DUMMIES, length_i);
              end
              CMD_WRITE: begin
                if (length_i == '0) begin
                  job.en[SLOT_PRE] = 1'b1;
                  job.pre          = info_item(KIND_DONE, 8'd0, 32'd0);
                end else begin
                  phase_d = PH_DIV;
                  cnt_d   = 1'b1;
                end
              end
              CMD_SECTOR, CMD_PAGE: begin
                job.en[SLOT_H0]    = 1'b1;
                job.en[SLOT_H1]    = 1'b1;
                job.en[SLOT_H2]    = 1'b1;
                job.en[SLOT_H3]    = 1'b1;
                job.en[SLOT_POST0] = 1'b1;
                job.en[SLOT_POST1] = 1'b1;
                job.opc      = (command_i == CMD_SECTOR) ? OPC_SECTOR : OPC_PAGE;
                job.addr     = address_i;
                job.rel_last = 1'b1;
                job.post0    = spi_item(OPC_STATUS, 1'b1, 1'b0, 1'b0);
                job.post1    = spi_item(FILLER, 1'b0, 1'b0, 1'b1);
                phase_d      = PH_POLL;
              end
              default: begin
                gather_d           = '0;
                dum_d              = 3'(ID_BYTES);
                job.en[SLOT_PRE]   = 1'b1;
                job.en[SLOT_POST0] = 1'b1;
                job.pre            = spi_item(OPC_RDID, 1'b1, 1'b0, 1'b0);
                job.post0          = spi_item(FILLER, 1'b0, 1'b0, 1'b1);
                phase_d            = PH_ID;
              end
            endcase
          end
        end
        OP_WDATA: begin
          if (phase_q == PH_WDATA) begin
            room_d   = pr_new;
            left_d   = bl_new;
            cursor_d = cursor_q + ADDR_W'(1);
            // The page offset restarts at the end of a page and when the cursor wraps around the address space.
            if (cursor_q == '1 || off_q == PAGE_MAX) begin
              off_d = '0;
            end else begin
              off_d = off_q + OW'(1);
            end
            job.en[SLOT_PRE] = 1'b1;
            if (pr_new == '0) begin
              job.pre            = spi_item(data_byte_i, 1'b0, 1'b1, 1'b0);
              job.en[SLOT_POST0] = 1'b1;
              job.en[SLOT_POST1] = 1'b1;
              job.post0          = spi_item(OPC_STATUS, 1'b1, 1'b0, 1'b0);
              job.post1          = spi_item(FILLER, 1'b0, 1'b0, 1'b1);
              phase_d            = PH_POLL;
            end else begin
              job.pre = spi_item(data_byte_i, 1'b0, 1'b0, 1'b0);
            end
          end
        end
        OP_REPLY: begin
          case (phase_q)
            PH_DUMMY: begin
              dum_d            = dl_new;
              job.en[SLOT_PRE] = 1'b1;
              job.pre          = rc_item(dl_new, left_q);
              phase_d          = rc_phase(dl_new, left_q);
            end
            PH_RDATA: begin
              left_d             = left_q - LEN_W'(1);
              job.en[SLOT_PRE]   = 1'b1;
              job.en[SLOT_POST0] = 1'b1;
              job.pre            = info_item(KIND_HOST, data_byte_i, 32'd0);
              job.post0          = rc_item(dum_q, left_q - LEN_W'(1));
              phase_d            = rc_phase(dum_q, left_q - LEN_W'(1));
            end
            PH_ID: begin
              gather_d         = gather_new;
              dum_d            = dl_new;
              job.en[SLOT_PRE] = 1'b1;
              if (dl_new != 3'd0) begin
                job.pre = spi_item(FILLER, 1'b0, dl_new == 3'd1, 1'b1);
              end else begin
                job.pre = info_item(KIND_DONE, 8'd0, gather_new);
                phase_d = PH_IDLE;
              end
            end
            PH_POLL: begin
              job.en[SLOT_PRE] = 1'b1;
              if (!data_byte_i[READY_POS]) begin
                job.pre = spi_item(FILLER, 1'b0, 1'b0, 1'b1);
              end else begin
                job.pre = info_item(KIND_DESELECT, 8'd0, 32'd0);
                if (cmd_q == CMD_WRITE && left_q != '0) begin
                  room_d          = piece_room(off_q, left_q);
                  job.en[SLOT_H0] = 1'b1;
                  job.en[SLOT_H1] = 1'b1;
                  job.en[SLOT_H2] = 1'b1;
                  job.en[SLOT_H3] = 1'b1;
                  job.opc         = OPC_WRITE;
                  job.addr        = cursor_q;
                  job.rel_last    = 1'b0;
                  phase_d         = PH_WDATA;
                end else begin
                  job.en[SLOT_POST0] = 1'b1;
                  job.post0          = info_item(KIND_DONE, 8'd0, 32'd0);
                  phase_d            = PH_IDLE;
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign push_o.valid = (job.en != '0);
  assign push_o.job   = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cmd_q    <= '0;
      cursor_q <= '0;
      left_q   <= '0;
      room_q   <= '0;
      off_q    <= '0;
      dum_q    <= '0;
      gather_q <= '0;
      cnt_q    <= 1'b0;
      quot_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      cursor_q <= cursor_d;
      left_q   <= left_d;
      room_q   <= room_d;
      off_q    <= off_d;
      dum_q    <= dum_d;
      gather_q <= gather_d;
      cnt_q    <= cnt_d;
      quot_q   <= quot_d;
    end
  end

`ifndef SYNTH
  a_no_accept_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DIV |-> !in_ready_o)
    else $error("input accepted during page offset computation");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> q_room_i)
    else $error("job pushed into a full queue");
  a_offset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= PAGE_MAX)
    else $error("page offset out of range");
`endif

endmodule

// File: design/sfcs_queue.sv
module sfcs_queue import sfcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_push_t push_i,
  output logic      room_o,
  output logic      head_valid_o,
  output job_t      head_o,
  input  logic      pop_i
);

  logic [1:0] cnt_q, cnt_d;
  job_t       e0_q, e0_d;
  job_t       e1_q, e1_d;

  assign room_o       = (cnt_q != 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = e0_q;

  always_comb begin
    cnt_d = cnt_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    case ({push_i.valid, pop_i})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          e0_d = push_i.job;
        end else begin
          e1_d = push_i.job;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        e0_d  = e1_q;
        cnt_d = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          e0_d = push_i.job;
        end else begin
          e0_d = e1_q;
          e1_d = push_i.job;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

// File: design/sfcs_back.sv
module sfcs_back import sfcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  spi_byte_o,
  output logic        select_before_o,
  output logic        release_after_o,
  output logic        wants_reply_o,
  output logic [7:0]  host_byte_o,
  output logic [31:0] id_word_o,
  output logic        last_o
);

  logic [2:0]           pos_q, pos_d;
  logic                 valid_q;
  item_t                item_q;
  logic                 last_q;

  logic [NUM_SLOTS-1:0] avail;
  logic [NUM_SLOTS-1:0] above;
  logic [2:0]           cur;
  logic                 last;
  logic                 emit;
  item_t                item;

  assign avail = head_i.en & ~((NUM_SLOTS'(1) << pos_q) - NUM_SLOTS'(1));

  always_comb begin
    cur = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        cur = 3'(i);
      end
    end
  end

  assign above = avail & ~(NUM_SLOTS'(1) << cur);
  assign last  = (above == '0);
  assign emit  = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o = emit && last;

  always_comb begin
    case (cur)
      3'(SLOT_PRE):   item = head_i.pre;
      3'(SLOT_H0):    item = spi_item(head_i.opc, 1'b1, 1'b0, 1'b0);
      3'(SLOT_H1):    item = spi_item(head_i.addr[23:16], 1'b0, 1'b0, 1'b0);
      3'(SLOT_H2):    item = spi_item(head_i.addr[15:8], 1'b0, 1'b0, 1'b0);
      3'(SLOT_H3):    item = spi_item(head_i.addr[7:0], 1'b0, head_i.rel_last, 1'b0);
      3'(SLOT_POST0): item = head_i.post0;
      default:        item = head_i.post1;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    if (emit) begin
      pos_d = last ? 3'd0 : cur + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      item_q <= item;
      last_q <= last;
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = item_q.kind;
  assign spi_byte_o      = item_q.spi_byte;
  assign select_before_o = item_q.sel;
  assign release_after_o = item_q.rel;
  assign wants_reply_o   = item_q.reply;
  assign host_byte_o     = item_q.host_byte;
  assign id_word_o       = item_q.id_word;
  assign last_o          = last_q;

`ifndef SYNTH
  a_mid_job_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 3'd0 |-> head_valid_i)
    else $error("job head vanished while being expanded");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < 3'(NUM_SLOTS))
    else $error("slot position out of range");
  a_emit_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> avail != '0)
    else $error("result emitted from a job with no slot left");
`endif

endmodule

// File: design/serial_flash_command_sequencer_unit.sv
// A result is registered in the job queue and then in the output register of the back end.
// Throughput: one input beat per cycle while the queue has room and no write divide runs,
// and one result beat per cycle while out_ready allows; a two-job queue decouples the sides.
// A write request first holds the front end while it computes the page offset with a
// reciprocal multiply, and then queues its program command once the queue has room.
// Reset is asynchronous and active low; it returns the sequencer to idle with the queue empty.
module serial_flash_command_sequencer_unit import sfcs_pkg::*; #(
  parameter int PAGE_BYTES   = 528,
  parameter int READ_DUMMIES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  command_i,
  input  logic [23:0] address_i,
  input  logic [15:0] length_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  spi_byte_o,
  output logic        select_before_o,
  output logic        release_after_o,
  output logic        wants_reply_o,
  output logic [7:0]  host_byte_o,
  output logic [31:0] id_word_o,
  output logic        last_o
);

  job_push_t push;
  logic      q_room;
  logic      head_valid;
  job_t      head;
  logic      pop;

  sfcs_front #(
    .PAGE_BYTES  (PAGE_BYTES),
    .READ_DUMMIES(READ_DUMMIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .command_i  (command_i),
    .address_i  (address_i),
    .length_i   (length_i),
    .data_byte_i(data_byte_i),
    .q_room_i   (q_room),
    .push_o     (push)
  );

  sfcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (q_room),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  sfcs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .spi_byte_o     (spi_byte_o),
    .select_before_o(select_before_o),
    .release_after_o(release_after_o),
    .wants_reply_o  (wants_reply_o),
    .host_byte_o    (host_byte_o),
    .id_word_o      (id_word_o),
    .last_o         (last_o)
  );

endmodule
